FILE: design/column_to_span_converter_top_macros.svh
// Assertion macros shared by the span converter RTL.
// Depends on signals named clock and reset in the including scope.
`ifndef COLUMN_TO_SPAN_CONVERTER_TOP_MACROS_SVH
`define COLUMN_TO_SPAN_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSPAN_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CSPAN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/cspan_pkg.sv
// Shared constants, packet type and row clamp for the span converter.
// No dependencies; used by every module of the block.
package cspan_pkg;

   localparam int SCREEN_HEIGHT = 64;            // rows on screen, 8 to 64
   localparam int ROW_W         = 6;             // row field width
   localparam int BOUND_W       = ROW_W + 1;     // row bound, can hold SCREEN_HEIGHT
   localparam int COL_W         = 10;            // column field width
   localparam int REQ_TDATA_W   = 24;
   localparam int RSP_TDATA_W   = 32;

   // One word moving down the cell chain. Every word carries the write window
   // (rows covered now and not covered before); a close word also names a row
   // and collects that row's start column on its way.
   typedef struct packed {
      logic               valid;
      logic               span_v;
      logic               last;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   x;
      logic [COL_W-1:0]   start;
      logic [BOUND_W-1:0] ot;
      logic [BOUND_W-1:0] ob;
      logic [BOUND_W-1:0] nt;
      logic [BOUND_W-1:0] nb;
   } pkt_type;

   function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] v);
      logic [ROW_W-1:0] r;
      r = v;
      if (v > ROW_W'(SCREEN_HEIGHT - 1)) begin
         r = ROW_W'(SCREEN_HEIGHT - 1);
      end
      return r;
   endfunction

endpackage

FILE: design/cspan_cell.sv
// One row cell of the span converter chain: start column of its row.
// Depends on cspan_pkg.
module cspan_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic [cspan_pkg::ROW_W-1:0] row_id,
   input  cspan_pkg::pkt_type        pkt_i,
   output cspan_pkg::pkt_type        pkt_o
);

   logic [cspan_pkg::COL_W-1:0]   start_ff;
   logic [cspan_pkg::COL_W-1:0]   start_in;
   cspan_pkg::pkt_type            pkt_ff;
   cspan_pkg::pkt_type            pkt_in;
   logic [cspan_pkg::BOUND_W-1:0] row7;
   logic                          in_new;
   logic                          in_old;
   logic                          hit;

   assign row7   = {1'b0, row_id};
   assign in_new = (row7 >= pkt_i.nt) && (row7 <= pkt_i.nb);
   assign in_old = (row7 >= pkt_i.ot) && (row7 <= pkt_i.ob);
   assign hit    = pkt_i.valid && pkt_i.span_v && (pkt_i.row == row_id);

   always_comb begin
      pkt_in = pkt_i;
      if (hit) begin
         pkt_in.start = start_ff;
      end
      // open rows take the current column; repeats within one column are harmless
      start_in = start_ff;
      if (adv && pkt_i.valid && in_new && !in_old) begin
         start_in = pkt_i.x;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      if (reset) begin
         pkt_ff.valid <= 1'b0;
      end else if (adv) begin
         pkt_ff <= pkt_in;
      end
   end

   assign pkt_o = pkt_ff;

endmodule

FILE: design/cspan_seq.sv
// Column sequencer: steps through closed rows and feeds words into the cell chain.
// Depends on cspan_pkg and column_to_span_converter_top_macros.svh.
`include "column_to_span_converter_top_macros.svh"

module cspan_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [cspan_pkg::COL_W-1:0] column,
   input  logic [cspan_pkg::ROW_W-1:0] top_row,
   input  logic [cspan_pkg::ROW_W-1:0] bottom_row,
   input  logic                        column_empty,
   input  logic                        adv,
   output cspan_pkg::pkt_type          pkt_o
);

   typedef enum logic [1:0] {
      IDLE = 2'b01,
      RUN  = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic [cspan_pkg::ROW_W-1:0]   prev_top_ff, prev_top_in;
   logic [cspan_pkg::ROW_W-1:0]   prev_bot_ff, prev_bot_in;
   logic                          prev_empty_ff, prev_empty_in;
   logic [cspan_pkg::BOUND_W-1:0] t1_ff, t1_in;
   logic [cspan_pkg::BOUND_W-1:0] b1_ff, b1_in;
   logic [cspan_pkg::BOUND_W-1:0] ot_ff, ot_in;
   logic [cspan_pkg::BOUND_W-1:0] ob_ff, ob_in;
   logic [cspan_pkg::BOUND_W-1:0] nt_ff, nt_in;
   logic [cspan_pkg::BOUND_W-1:0] nb_ff, nb_in;
   logic [cspan_pkg::COL_W-1:0]   x_ff, x_in;

   logic [cspan_pkg::ROW_W-1:0]   top_c;
   logic [cspan_pkg::ROW_W-1:0]   bot_c;
   logic                          empty;
   logic                          accept;
   logic                          close_lo;
   logic                          close_hi;
   logic [cspan_pkg::BOUND_W-1:0] t1_step;
   logic [cspan_pkg::BOUND_W-1:0] b1_step;
   logic                          final_step;
   logic [cspan_pkg::BOUND_W-1:0] row7;
   logic                          close_out;
   logic                          row_old;
   logic                          row_new;
   logic                          prev_zero;

   function automatic logic [cspan_pkg::BOUND_W-1:0] BOUND_W_ONE(input logic b);
      return {{(cspan_pkg::BOUND_W-1){1'b0}}, b};
   endfunction

   assign top_c = cspan_pkg::clamp_row(top_row);
   assign bot_c = cspan_pkg::clamp_row(bottom_row);
   assign empty = column_empty || (top_c > bot_c);

   // top edge ascending first, then bottom edge descending
   assign close_lo = (nt_ff > t1_ff) && (t1_ff <= b1_ff);
   assign close_hi = !close_lo && (nb_ff < b1_ff) && (t1_ff <= b1_ff);
   assign t1_step  = t1_ff + BOUND_W_ONE(close_lo);
   assign b1_step  = b1_ff - BOUND_W_ONE(close_hi);
   assign final_step = !(((nt_ff > t1_step) || (nb_ff < b1_step)) && (t1_step <= b1_step));

   assign in_ready = (state_ff == IDLE) || ((state_ff == RUN) && adv && final_step);
   assign accept   = in_valid && in_ready;

   always_comb begin
      pkt_o.valid  = (state_ff == RUN);
      pkt_o.span_v = close_lo || close_hi;
      pkt_o.last   = (close_lo || close_hi) && final_step;
      pkt_o.row    = close_lo ? t1_ff[cspan_pkg::ROW_W-1:0] : b1_ff[cspan_pkg::ROW_W-1:0];
      pkt_o.x      = x_ff;
      pkt_o.start  = '0;
      pkt_o.ot     = ot_ff;
      pkt_o.ob     = ob_ff;
      pkt_o.nt     = nt_ff;
      pkt_o.nb     = nb_ff;
   end

   always_comb begin
      state_in      = state_ff;
      prev_top_in   = prev_top_ff;
      prev_bot_in   = prev_bot_ff;
      prev_empty_in = prev_empty_ff;
      t1_in         = t1_ff;
      b1_in         = b1_ff;
      ot_in         = ot_ff;
      ob_in         = ob_ff;
      nt_in         = nt_ff;
      nb_in         = nb_ff;
      x_in          = x_ff;
      case (state_ff)
         IDLE: begin
         end
         RUN: begin
            if (adv) begin
               t1_in = t1_step;
               b1_in = b1_step;
               if (final_step) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      if (accept) begin
         // an empty range is a top below every row and a bottom of zero
         if (prev_empty_ff) begin
            t1_in = cspan_pkg::BOUND_W'(cspan_pkg::SCREEN_HEIGHT);
            b1_in = '0;
         end else begin
            t1_in = {1'b0, prev_top_ff};
            b1_in = {1'b0, prev_bot_ff};
         end
         ot_in = t1_in;
         ob_in = b1_in;
         if (empty) begin
            nt_in         = cspan_pkg::BOUND_W'(cspan_pkg::SCREEN_HEIGHT);
            nb_in         = '0;
            prev_top_in   = '0;
            prev_bot_in   = '0;
            prev_empty_in = 1'b1;
         end else begin
            nt_in         = {1'b0, top_c};
            nb_in         = {1'b0, bot_c};
            prev_top_in   = top_c;
            prev_bot_in   = bot_c;
            prev_empty_in = 1'b0;
         end
         x_in     = column;
         state_in = RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         prev_top_ff   <= '0;
         prev_bot_ff   <= '0;
         prev_empty_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         prev_top_ff   <= prev_top_in;
         prev_bot_ff   <= prev_bot_in;
         prev_empty_ff <= prev_empty_in;
      end
      t1_ff <= t1_in;
      b1_ff <= b1_in;
      ot_ff <= ot_in;
      ob_ff <= ob_in;
      nt_ff <= nt_in;
      nb_ff <= nb_in;
      x_ff  <= x_in;
   end

   assign row7      = {1'b0, pkt_o.row};
   assign close_out = pkt_o.valid && pkt_o.span_v;
   assign row_old   = (row7 >= ot_ff) && (row7 <= ob_ff);
   assign row_new   = (row7 >= nt_ff) && (row7 <= nb_ff);
   assign prev_zero = (prev_top_ff == '0) && (prev_bot_ff == '0);

   `CSPAN_ASSERT(a_close_was_open, close_out, row_old, "closed row was not open")
   `CSPAN_ASSERT(a_close_not_covered, close_out, !row_new, "closed row is still covered")
   `CSPAN_ASSERT_NEXT(a_accept_runs, accept, state_ff == RUN, "accepted column not sequenced")
   `CSPAN_ASSERT(a_empty_prev_zero, prev_empty_ff, prev_zero, "empty state keeps stale bounds")

endmodule

FILE: design/column_to_span_converter_top.sv
// Top level of the column-to-span converter: sequencer plus a chain of row cells.
// Depends on cspan_pkg, cspan_seq and cspan_cell.
//
// Use: feed one word per screen column on req_* (column, top row, bottom row in
// req_tdata, column_empty in req_tuser). For each column the block closes every
// row that was open in the previous column and is not covered now: top rows in
// ascending order, then bottom rows in descending order, one span word each on
// rsp_* (row, start column, end column = column - 1). rsp_tlast marks the last
// span caused by a column; a column that closes nothing gives no word.
// Throughput: the sequencer takes one step per row closed, or one step for a
// column that closes nothing, stepping only while the chain advances, and takes
// the next column in the cycle of its last step; one span leaves per cycle at most.
// Each word walks the chain of SCREEN_HEIGHT cells, one cell a cycle while the
// chain advances, so the spans of a column leave on rsp_* in the order made.
// Rows opened by a column take its column number in their cell as the word
// passes, so later columns always see earlier writes.
// Reset: no rows open; the start-column store is not cleared, since a row is
// always opened before it can close. Stall: while rsp_tvalid waits for
// rsp_tready the whole chain and the sequencer hold; an idle sequencer still
// takes one column.
module column_to_span_converter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [9:0] column, [15:10] top_row, [21:16] bottom_row, [23:22] zero
   input  logic [cspan_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] column_empty
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [5:0] span_row, [15:6] span_x_start, [25:16] span_x_end, [31:26] zero
   output logic [cspan_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // last_of_run
   output logic                              rsp_tlast
);

   localparam int H = cspan_pkg::SCREEN_HEIGHT;

   cspan_pkg::pkt_type           chain [0:H];
   logic                         adv;
   logic [cspan_pkg::COL_W-1:0]  x_end;

   // the last cell's register is the output stage; advance when it is free or taken
   assign rsp_tvalid = chain[H].valid && chain[H].span_v;
   assign adv        = !rsp_tvalid || rsp_tready;

   cspan_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .column       (req_tdata[cspan_pkg::COL_W-1:0]),
      .top_row      (req_tdata[cspan_pkg::COL_W +: cspan_pkg::ROW_W]),
      .bottom_row   (req_tdata[cspan_pkg::COL_W + cspan_pkg::ROW_W +: cspan_pkg::ROW_W]),
      .column_empty (req_tuser),
      .adv          (adv),
      .pkt_o        (chain[0])
   );

   // one cell per screen row, each passing the word to the next row's cell
   for (genvar i = 0; i < H; i++) begin : g_cell
      cspan_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .row_id (cspan_pkg::ROW_W'(i)),
         .pkt_i  (chain[i]),
         .pkt_o  (chain[i+1])
      );
   end

   // end column is the previous column, wrapping at zero
   assign x_end = chain[H].x - cspan_pkg::COL_W'(1);

   assign rsp_tdata = {
      (cspan_pkg::RSP_TDATA_W - cspan_pkg::ROW_W - 2 * cspan_pkg::COL_W)'(0),
      x_end,
      chain[H].start,
      chain[H].row
   };
   assign rsp_tlast = chain[H].last;

endmodule
